### rtl/assert_macros.svh
// assertion macros shared by the rtl files that check their own logic
// no dependencies; pulled in with an include where assertions are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define SWM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SWM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/swm_pkg.sv
// package for the sliding window maximum unit: widths, payload and cell control types
// no dependencies
`default_nettype none

package swm_pkg;

    localparam int SAMPLE_WIDTH       = 32;
    localparam int WIN_W              = 5;
    localparam int MAX_WINDOW_DEFAULT = 16;

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;

    typedef struct packed {
        t_sample sample;
        logic    start_seq;
        logic    end_seq;
    } t_swm_in;

    typedef struct packed {
        t_sample window_max;
        logic    final_window;
    } t_swm_out;

    // broadcast from the top level to every cell of the chain
    typedef struct packed {
        logic             shift;
        logic             start;
        logic [WIN_W-1:0] window;
        t_sample          sample;
    } t_swm_ctl;

endpackage

`default_nettype wire

### rtl/swm_cell.sv
// one cell of the sample chain: holds one sample and its candidate flag
// depends on swm_pkg
`default_nettype none

module swm_cell #(
    parameter int INDEX = 0
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire swm_pkg::t_swm_ctl i_ctl,
    input  wire swm_pkg::t_sample  i_prev_value,
    input  wire logic              i_prev_flag,
    output swm_pkg::t_sample       o_value,
    output logic                   o_flag
);

    swm_pkg::t_sample r_value;
    logic             r_flag;
    logic             n_flag;

    // a sample stays a candidate while it is inside the window and greater
    // than every newer sample; the head cell holds a candidate once a sample has shifted in
    always_comb begin
        if (INDEX == 0) begin
            n_flag = 1'b1;
        end else begin
            n_flag = i_prev_flag && !i_ctl.start
                  && (32'(INDEX) < 32'(i_ctl.window))
                  && (i_prev_value > i_ctl.sample);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag <= 1'b0;
        end else if (i_ctl.shift) begin
            r_flag <= n_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_value <= i_prev_value;
        end
    end

    assign o_value = r_value;
    assign o_flag  = r_flag;

endmodule

`default_nettype wire

### rtl/swm_select.sv
// picks the oldest candidate of the chain, which is the window maximum
// depends on swm_pkg
`default_nettype none

module swm_select #(
    parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEFAULT
) (
    input  wire logic [MAX_WINDOW-1:0] i_flags,
    input  wire swm_pkg::t_sample      i_values [MAX_WINDOW],
    output swm_pkg::t_sample           o_value
);

    logic [MAX_WINDOW-1:0] w_sel;
    swm_pkg::t_sample      w_value;

    // one-hot pick of the highest flagged cell, then an and-or mux
    always_comb begin
        w_value = '0;
        for (int k = 0; k < MAX_WINDOW; k++) begin
            w_sel[k] = i_flags[k] && !(|(i_flags >> (k + 1)));
            w_value  = w_value | (w_sel[k] ? i_values[k] : '0);
        end
    end

    assign o_value = w_value;

endmodule

`default_nettype wire

### rtl/sliding_window_maximum_unit.sv
// top level of the sliding window maximum unit: handshakes, counters, cell chain
// depends on swm_pkg, swm_cell, swm_select and assert_macros.svh
//
//  channel   valid        ready        payload
//  input     i_valid      o_ready      i_data  (sample, start_seq, end_seq)
//  output    o_valid      i_ready      o_data  (window_max, final_window)
//  config    i_cfg_valid  o_cfg_ready  i_cfg_data (window_size)
//
// an item shifts into the cell chain in the cycle it is accepted; its result
// is picked from the chain once the output register can load, and lands there
// one item per cycle sustained while the output is not stalled; the output register and the pending stage
// set the throughput, and a stalled output holds the chain after one item
// synchronous active-low reset clears candidate flags, counters and valids;
// window_size resets to 1
`default_nettype none
`include "assert_macros.svh"

module sliding_window_maximum_unit #(
    parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEFAULT
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire swm_pkg::t_swm_in          i_data,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output swm_pkg::t_swm_out              o_data,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [swm_pkg::WIN_W-1:0] i_cfg_data
);

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);

    logic [swm_pkg::WIN_W-1:0] r_window;
    logic [swm_pkg::WIN_W-1:0] w_eff_window;
    logic [CNT_W-1:0]          r_seen;
    logic [CNT_W-1:0]          n_seen;
    logic                      n_emit;
    logic                      r_pend;
    logic                      r_pend_emit;
    logic                      r_pend_last;
    logic                      r_out_valid;
    swm_pkg::t_swm_out         r_out;
    logic                      w_can_load;
    logic                      w_accept;
    swm_pkg::t_swm_ctl         w_ctl;
    logic [MAX_WINDOW-1:0]     w_flags;
    swm_pkg::t_sample          w_values [MAX_WINDOW];
    swm_pkg::t_sample          w_front;

    assign w_can_load  = !r_out_valid || i_ready;
    assign o_ready     = !r_pend || w_can_load;
    assign w_accept    = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_data      = r_out;

    // zero means one, anything past the chain length means the whole chain
    always_comb begin
        if (r_window == '0) begin
            w_eff_window = swm_pkg::WIN_W'(1);
        end else if (32'(r_window) > 32'(MAX_WINDOW)) begin
            w_eff_window = swm_pkg::WIN_W'(MAX_WINDOW);
        end else begin
            w_eff_window = r_window;
        end
    end

    always_comb begin
        if (i_data.start_seq) begin
            n_seen = CNT_W'(1);
        end else if (32'(r_seen) < 32'(MAX_WINDOW)) begin
            n_seen = r_seen + CNT_W'(1);
        end else begin
            n_seen = r_seen;
        end
        n_emit = 32'(n_seen) >= 32'(w_eff_window);
    end

    assign w_ctl.shift  = w_accept;
    assign w_ctl.start  = i_data.start_seq;
    assign w_ctl.window = w_eff_window;
    assign w_ctl.sample = i_data.sample;

    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
        swm_pkg::t_sample w_prev_value;
        logic             w_prev_flag;

        if (g == 0) begin : g_head
            assign w_prev_value = i_data.sample;
            assign w_prev_flag  = 1'b1;
        end else begin : g_body
            assign w_prev_value = w_values[g-1];
            assign w_prev_flag  = w_flags[g-1];
        end

        swm_cell #(
            .INDEX (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_prev_value (w_prev_value),
            .i_prev_flag  (w_prev_flag),
            .o_value      (w_values[g]),
            .o_flag       (w_flags[g])
        );
    end

    swm_select #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_select (
        .i_flags  (w_flags),
        .i_values (w_values),
        .o_value  (w_front)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= swm_pkg::WIN_W'(1);
            r_seen      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_window <= i_cfg_data;
            end
            if (w_accept) begin
                r_seen <= n_seen;
                r_pend <= 1'b1;
            end else if (w_can_load) begin
                r_pend <= 1'b0;
            end
            // a pending item without a result just empties the output side
            if (r_pend && w_can_load) begin
                r_out_valid <= r_pend_emit;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pend_emit <= n_emit;
            r_pend_last <= i_data.end_seq;
        end
        if (r_pend && w_can_load) begin
            r_out.window_max   <= w_front;
            r_out.final_window <= r_pend_last;
        end
    end

    `SWM_ASSERT_NOW(a_head_candidate, i_clk, i_rst_n, r_pend, w_flags[0],
        "pending item but head cell holds no candidate")
    `SWM_ASSERT_NEXT(a_accept_pends, i_clk, i_rst_n, w_accept, r_pend,
        "accepted item did not reach the pending stage")
    `SWM_ASSERT_NEXT(a_result_loads, i_clk, i_rst_n, r_pend && w_can_load,
        r_out_valid == $past(r_pend_emit), "output valid does not follow pending result")
    `SWM_ASSERT_NOW(a_seen_bound, i_clk, i_rst_n, 1'b1, 32'(r_seen) <= 32'(MAX_WINDOW),
        "sample count passed the chain length")

endmodule

`default_nettype wire

### test/tb.sv
// testbench for sliding_window_maximum_unit: directed table, then random sequences
// checked against an in-bench monotonic-queue predictor; depends on swm_pkg and sliding_window_maximum_unit
module tb;

    localparam int MAXW          = swm_pkg::MAX_WINDOW_DEFAULT;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 80;
    localparam int NUM_PHASES    = 26;
    localparam int PHASE_ITEMS   = 60;
    localparam int HOLD_PHASE    = 3;
    localparam int PAUSE_PHASE   = 6;
    localparam swm_pkg::t_sample SMP_MIN = {1'b1, {(swm_pkg::SAMPLE_WIDTH-1){1'b0}}};
    localparam swm_pkg::t_sample SMP_MAX = {1'b0, {(swm_pkg::SAMPLE_WIDTH-1){1'b1}}};

    typedef enum logic [1:0] {ROW_ITEM, ROW_CFG} t_row_kind;
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_VALUE} t_check;
    typedef enum int {SHAPE_WIDE, SHAPE_NARROW, SHAPE_RISING, SHAPE_FALLING,
                      SHAPE_CORNERS} t_seq_shape;
    typedef enum int {RX_ALWAYS, RX_COIN, RX_TOGGLE, RX_SPARSE} t_rx_mode;

    typedef struct {
        t_row_kind                 kind;
        swm_pkg::t_swm_in          item;
        logic [swm_pkg::WIN_W-1:0] cfg;
        t_check                    chk;
        swm_pkg::t_swm_out         want;
    } t_dir_row;

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_valid     = 1'b0;
    logic                      o_ready;
    swm_pkg::t_swm_in          i_data      = '0;
    logic                      o_valid;
    logic                      i_ready     = 1'b0;
    swm_pkg::t_swm_out         o_data;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [swm_pkg::WIN_W-1:0] i_cfg_data  = '0;

    // predictor state: candidate queue, oldest first, strictly decreasing
    logic [swm_pkg::WIN_W-1:0] win_reg = 5'd1;
    swm_pkg::t_sample          cand_val [MAXW];
    logic [swm_pkg::WIN_W-1:0] cand_pos [MAXW];
    int                        cand_cnt = 0;
    logic [swm_pkg::WIN_W-1:0] next_pos = '0;   // wraps at 32, twice the window depth
    int                        seen_cnt = 0;

    swm_pkg::t_swm_out pending_max[$];
    t_dir_row          dir_rows[$];
    int                error_count = 0;
    int                burst_left  = 0;
    bit                rx_hold_req = 1'b0;

    sliding_window_maximum_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int eff_window();
        if (win_reg == 0)
            return 1;
        if (win_reg > MAXW)
            return MAXW;
        return int'(win_reg);
    endfunction

    function automatic bit predict_window_max(input swm_pkg::t_swm_in d,
                                              output swm_pkg::t_swm_out r);
        int                        w;
        int                        k;
        logic [swm_pkg::WIN_W-1:0] age;
        bit                        dropping;
        w = eff_window();
        if (d.start_seq) begin
            cand_cnt = 0;
            next_pos = '0;
            seen_cnt = 0;
        end
        // age out the front of the queue
        dropping = 1'b1;
        while (cand_cnt > 0 && dropping) begin
            age = next_pos - cand_pos[0];
            if (age >= w) begin
                for (k = 0; k < cand_cnt - 1; k++) begin
                    cand_val[k] = cand_val[k+1];
                    cand_pos[k] = cand_pos[k+1];
                end
                cand_cnt--;
            end else begin
                dropping = 1'b0;
            end
        end
        while (cand_cnt > 0 && $signed(cand_val[cand_cnt-1]) <= $signed(d.sample))
            cand_cnt--;
        if (cand_cnt < MAXW) begin
            cand_val[cand_cnt] = d.sample;
            cand_pos[cand_cnt] = next_pos;
            cand_cnt++;
        end
        next_pos = next_pos + 1'b1;
        if (seen_cnt < MAXW)
            seen_cnt++;
        r.window_max   = cand_val[0];
        r.final_window = d.end_seq;
        return seen_cnt >= w;
    endfunction

    function automatic t_dir_row item_row(input swm_pkg::t_sample s, input bit st,
                                          input bit en, input t_check chk,
                                          input swm_pkg::t_sample m);
        t_dir_row r;
        r.kind              = ROW_ITEM;
        r.item.sample       = s;
        r.item.start_seq    = st;
        r.item.end_seq      = en;
        r.cfg               = '0;
        r.chk               = chk;
        r.want.window_max   = m;
        r.want.final_window = en;
        return r;
    endfunction

    function automatic t_dir_row cfg_row(input logic [swm_pkg::WIN_W-1:0] v);
        t_dir_row r;
        r       = item_row('0, 1'b0, 1'b0, CHK_NONE, '0);
        r.kind  = ROW_CFG;
        r.cfg   = v;
        return r;
    endfunction

    function automatic void add_row(input t_dir_row r);
        dir_rows = {dir_rows, r};
    endfunction

    function automatic void queue_result(input swm_pkg::t_swm_out x);
        pending_max = {pending_max, x};
    endfunction

    task automatic flag_error(input string what, input swm_pkg::t_swm_out want,
                              input swm_pkg::t_swm_out got);
        if (error_count < 10)
            $display("%s: expected max %0d last %0b, got max %0d last %0b", what,
                     want.window_max, want.final_window, got.window_max, got.final_window);
        error_count++;
    endtask

    // stop offering and wait for every pending result, then settle
    task automatic wait_idle(input int settle);
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_max.size() != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [swm_pkg::WIN_W-1:0] v);
        wait_idle(SETTLE_CYCLES);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        win_reg = v;
    endtask

    task automatic send_checked(input swm_pkg::t_swm_in d, input bit gappy,
                                input t_check chk, input swm_pkg::t_swm_out typed);
        swm_pkg::t_swm_out r;
        bit                has_res;
        if (gappy && burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0)
            burst_left--;
        i_valid <= 1'b1;
        i_data  <= d;
        do @(posedge i_clk); while (!o_ready);
        has_res = predict_window_max(d, r);
        if (chk == CHK_VALUE)
            queue_result(typed);
        else if (chk == CHK_MODEL && has_res)
            queue_result(r);
    endtask

    task automatic send_sequence(input int len, input bit gappy, input bit broken);
        t_seq_shape       shape;
        swm_pkg::t_swm_in d;
        swm_pkg::t_sample base;
        int               step;
        int               i;
        shape = t_seq_shape'($urandom_range(0, 4));
        base  = $urandom;
        step  = $urandom_range(1, 1 << 20);
        for (i = 0; i < len; i++) begin
            case (shape)
                SHAPE_WIDE:    d.sample = $urandom;
                SHAPE_NARROW:  d.sample = int'($urandom_range(0, 8)) - 4;
                SHAPE_RISING:  d.sample = base + i * step;
                SHAPE_FALLING: d.sample = base - i * step;
                default: begin
                    case ($urandom_range(0, 3))
                        0:       d.sample = SMP_MIN;
                        1:       d.sample = SMP_MAX;
                        2:       d.sample = '0;
                        default: d.sample = '1;
                    endcase
                end
            endcase
            d.start_seq = (i == 0);
            d.end_seq   = (i == len - 1);
            // broken sequences: stray or missing start and end flags
            if (broken && $urandom_range(0, 5) == 0)
                d.start_seq = ~d.start_seq;
            if (broken && $urandom_range(0, 5) == 0)
                d.end_seq = ~d.end_seq;
            send_checked(d, gappy, CHK_MODEL, '0);
        end
    endtask

    // receiver: stall pattern of its own, plus a long hold on request
    initial begin
        t_rx_mode rx_mode;
        int       seg_left;
        int       n;
        rx_mode  = RX_ALWAYS;
        seg_left = 0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                i_ready <= 1'b0;
                for (n = 0; n < LONG_HOLD; n++)
                    @(posedge i_clk);
                rx_hold_req = 1'b0;
                i_ready <= 1'b1;
            end else begin
                if (seg_left == 0) begin
                    rx_mode  = t_rx_mode'($urandom_range(0, 3));
                    seg_left = $urandom_range(5, 60);
                end
                seg_left--;
                case (rx_mode)
                    RX_ALWAYS: i_ready <= 1'b1;
                    RX_COIN:   i_ready <= 1'($urandom_range(0, 1));
                    RX_TOGGLE: i_ready <= ~i_ready;
                    default:   i_ready <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        swm_pkg::t_swm_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_max.size() == 0) begin
                flag_error("result with nothing pending", '0, o_data);
            end else begin
                want = pending_max[0];
                pending_max.delete(0);
                if (o_data.window_max !== want.window_max ||
                    o_data.final_window !== want.final_window)
                    flag_error("window max mismatch", want, o_data);
            end
        end
    end

    initial begin
        #(12 * 400000);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int                        r;
        int                        phase;
        int                        phase_items;
        int                        len;
        logic [swm_pkg::WIN_W-1:0] wsel;
        bit                        gappy;

        // window 1 after reset: every sample is its own maximum
        add_row(item_row(SMP_MAX, 1'b1, 1'b0, CHK_VALUE, SMP_MAX));
        add_row(item_row(SMP_MIN, 1'b0, 1'b1, CHK_VALUE, SMP_MIN));
        add_row(item_row(-1, 1'b0, 1'b0, CHK_VALUE, -1));            // continues past end
        add_row(cfg_row(5'd0));                                      // zero acts as one
        add_row(item_row(0, 1'b0, 1'b1, CHK_VALUE, 0));
        add_row(cfg_row(5'd3));
        add_row(item_row(10, 1'b1, 1'b0, CHK_NONE, 0));
        add_row(item_row(20, 1'b0, 1'b0, CHK_NONE, 0));
        add_row(item_row(15, 1'b0, 1'b1, CHK_VALUE, 20));
        add_row(item_row(3, 1'b1, 1'b0, CHK_NONE, 0));               // shorter than window
        add_row(item_row(2, 1'b0, 1'b1, CHK_NONE, 0));
        add_row(item_row(SMP_MIN, 1'b1, 1'b0, CHK_NONE, 0));
        add_row(item_row(SMP_MIN, 1'b0, 1'b0, CHK_NONE, 0));
        add_row(item_row(SMP_MIN, 1'b0, 1'b0, CHK_VALUE, SMP_MIN));
        add_row(item_row(SMP_MAX, 1'b0, 1'b0, CHK_MODEL, 0));
        add_row(cfg_row(5'd2));                                      // shrink mid-sequence
        add_row(item_row(1, 1'b0, 1'b0, CHK_MODEL, 0));
        add_row(item_row(-5, 1'b0, 1'b0, CHK_MODEL, 0));
        add_row(cfg_row(5'd17));                                     // saturates to max
        add_row(item_row(100, 1'b1, 1'b0, CHK_MODEL, 0));
        add_row(item_row(99, 1'b0, 1'b0, CHK_MODEL, 0));
        add_row(item_row(101, 1'b0, 1'b0, CHK_MODEL, 0));
        add_row(item_row(-7, 1'b0, 1'b0, CHK_MODEL, 0));
        add_row(item_row(101, 1'b0, 1'b0, CHK_MODEL, 0));
        add_row(cfg_row(5'd4));
        add_row(item_row(8, 1'b0, 1'b0, CHK_MODEL, 0));
        add_row(item_row(-8, 1'b0, 1'b1, CHK_MODEL, 0));
        add_row(cfg_row(5'd31));                                     // grows, no start
        add_row(item_row(32'sh55555555, 1'b0, 1'b0, CHK_MODEL, 0));
        add_row(item_row(32'shAAAAAAAA, 1'b0, 1'b1, CHK_MODEL, 0));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < dir_rows.size(); r++) begin
            if (dir_rows[r].kind == ROW_CFG)
                write_window(dir_rows[r].cfg);
            else
                send_checked(dir_rows[r].item, 1'b1, dir_rows[r].chk, dir_rows[r].want);
        end

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            case ($urandom_range(0, 9))
                0:       wsel = 5'd0;
                1:       wsel = swm_pkg::WIN_W'($urandom_range(17, 31));
                2:       wsel = 5'd16;
                3:       wsel = 5'd1;
                default: wsel = swm_pkg::WIN_W'($urandom_range(1, 16));
            endcase
            write_window(wsel);
            gappy = ($urandom_range(0, 3) != 0);
            if (phase == HOLD_PHASE) begin
                // back-to-back items into a stalled output until the input stalls
                gappy       = 1'b0;
                rx_hold_req = 1'b1;
            end
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                if ($urandom_range(0, 4) == 0)
                    len = $urandom_range(1, 40);
                else
                    len = $urandom_range(1, 2 * eff_window() + 4);
                send_sequence(len, gappy, $urandom_range(0, 7) == 0);
                phase_items += len;
                if (phase == PAUSE_PHASE)
                    wait_idle(0);
            end
        end

        wait_idle(SETTLE_CYCLES);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
